### rtl/rfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfb_pkg
// Shared types, constants and arithmetic helpers of the fill and blend engine.
// ----------------------------------------------------------------------------
package rfb_pkg;

   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;

   localparam logic [2:0] KIND_CLEAR = 3'd0;
   localparam logic [2:0] KIND_RECT  = 3'd1;
   localparam logic [2:0] KIND_VGRAD = 3'd2;
   localparam logic [2:0] KIND_BLEND = 3'd3;
   localparam logic [2:0] KIND_READ  = 3'd4;

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   // How the fill loop produces each pixel.
   localparam logic [1:0] MODE_SOLID = 2'd0;
   localparam logic [1:0] MODE_GRAD  = 2'd1;
   localparam logic [1:0] MODE_BLEND = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GRAD,
      ST_RUN,
      ST_READ,
      ST_RESP
   } state_type;

   // Exact floor(v / 255) for v < 65280 by reciprocal multiply.
   function automatic logic [7:0] div255(input logic [15:0] v);
      logic [16:0] s;
      begin
         s = {1'b0, v} + 17'd1 + {9'd0, v[15:8]};
         div255 = s[15:8];
      end
   endfunction

   // One channel mix: (a * (255 - t) + b * t) / 255.
   function automatic logic [7:0] mix8(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] t);
      logic [15:0] p;
      begin
         p = a * (8'd255 - t) + b * t;
         mix8 = div255(p);
      end
   endfunction

   function automatic logic [23:0] mix24(input logic [23:0] a, input logic [23:0] b,
                                         input logic [7:0] t);
      begin
         mix24 = {mix8(a[23:16], b[23:16], t), mix8(a[15:8], b[15:8], t),
                  mix8(a[7:0], b[7:0], t)};
      end
   endfunction

endpackage

### rtl/rect_fill_blend_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_fill_blend_engine_top
// Clear, rectangle fill, vertical gradient, src-over blend and pixel read over an RGB888 store.
// ----------------------------------------------------------------------------
// After the accept cycle, a fill writes its clipped pixels through one memory
// write port and then closes before its response is offered; each gradient row
// first runs 24 divider steps and then sets the color; a blend pixel with partial
// alpha is read, then written; a read registers the pixel data, then the color.
// Throughput: one command at a time, the next one accepted after the response.
// Reset sets the frame size registers to 256, clamped to the maximum; the pixel store is not cleared.
module rect_fill_blend_engine_top #(
   parameter int MAX_WIDTH  = rfb_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = rfb_pkg::DEF_MAX_HEIGHT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic signed [15:0] req_size_w,
   input  logic signed [15:0] req_size_h,
   input  logic [23:0] req_color_a,
   input  logic [23:0] req_color_b,
   input  logic [7:0]  req_alpha,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [23:0] rsp_read_color,
   output logic [16:0] rsp_pixels_written,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [8:0]  csr_data
);
   import rfb_pkg::*;

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int CW    = AW + 1;

   // Pixel store.
   logic [23:0] mem [DEPTH];
   logic [23:0] rd_data_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [23:0]   mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= mem[mem_raddr];
   end

   // Configuration registers and effective frame size.
   logic [8:0] fw_ff, fh_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= 9'd256;
         fh_ff <= 9'd256;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_WIDTH:  fw_ff <= csr_data;
            CSR_HEIGHT: fh_ff <= csr_data;
            default: ;
         endcase
      end
   end

   logic signed [17:0] efw, efh;
   always_comb begin
      efw = (fw_ff == 9'd0) ? 18'sd1 : (32'(fw_ff) > MAX_WIDTH)
            ? 18'(MAX_WIDTH) : 18'(fw_ff);
      efh = (fh_ff == 9'd0) ? 18'sd1 : (32'(fh_ff) > MAX_HEIGHT)
            ? 18'(MAX_HEIGHT) : 18'(fh_ff);
   end

   // Command registers.
   state_type state_ff, state_in;
   logic [1:0]  mode_ff;
   logic signed [17:0] x0_ff, x1_ff, y1_ff, py_ff, px_ff, ytop_ff;
   logic [15:0] span_ff;
   logic [23:0] ca_ff, cb_ff, col_ff;
   logic [7:0]  a_ff;
   logic        phase_ff;        // blend: 0 read issued, 1 write
   logic [CW-1:0] cnt_ff;
   logic [23:0] rcol_ff;
   logic        rd_in_ff;
   logic [AW-1:0] ra_ff;

   // Serial divider for gradient t.
   logic [23:0] rem_ff;
   logic [23:0] quo_ff;
   logic [4:0]  dstep_ff;
   logic [24:0] div_r2;

   logic [AW-1:0] cur_addr;
   assign cur_addr = AW'(py_ff[HW-1:0]) * AW'(efw[WW-1:0]) + AW'(px_ff[WW-1:0]);

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign rsp_read_color = rcol_ff;
   assign rsp_pixels_written = 17'(cnt_ff);

   // Clipped bounds and load values of the offered command.
   logic signed [17:0] cx0, cy0, cx1, cy1, rx, ry;
   logic signed [17:0] ld_x0, ld_y0, ld_x1, ld_y1;
   logic [1:0]  ld_mode;
   always_comb begin
      rx  = 18'(req_pos_x);
      ry  = 18'(req_pos_y);
      cx0 = (rx < 0) ? 18'sd0 : rx;
      cy0 = (ry < 0) ? 18'sd0 : ry;
      cx1 = rx + 18'(req_size_w);
      cy1 = ry + 18'(req_size_h);
      if (cx1 > efw) cx1 = efw;
      if (cy1 > efh) cy1 = efh;
      ld_x0 = (req_kind == KIND_CLEAR) ? 18'sd0 : cx0;
      ld_y0 = (req_kind == KIND_CLEAR) ? 18'sd0 : cy0;
      ld_x1 = (req_kind == KIND_CLEAR) ? efw : cx1;
      ld_y1 = (req_kind == KIND_CLEAR) ? efh : cy1;
      if (req_kind == KIND_VGRAD) ld_mode = MODE_GRAD;
      else if (req_kind == KIND_BLEND && req_alpha != 8'd255) ld_mode = MODE_BLEND;
      else ld_mode = MODE_SOLID;
   end

   // Loop conditions of the pixel walk.
   logic run_live, pix_done, row_end, grad_next;
   always_comb begin
      run_live  = (py_ff < y1_ff) && (x0_ff < x1_ff);
      pix_done  = run_live && ((mode_ff != MODE_BLEND) || phase_ff);
      row_end   = !(px_ff + 18'sd1 < x1_ff);
      grad_next = (mode_ff == MODE_GRAD) && (py_ff + 18'sd1 < y1_ff);
      div_r2    = {rem_ff, quo_ff[23]};
   end

   // Next state and memory port control.
   always_comb begin
      state_in  = state_ff;
      mem_we    = 1'b0;
      mem_waddr = cur_addr;
      mem_wdata = (mode_ff == MODE_BLEND) ? mix24(rd_data_ff, ca_ff, a_ff) : col_ff;
      mem_raddr = (state_ff == ST_READ) ? ra_ff : cur_addr;
      unique case (state_ff)
         ST_IDLE: if (req_valid) begin
            unique case (req_kind)
               KIND_CLEAR: state_in = ST_RUN;
               KIND_RECT:  state_in = ST_RUN;
               KIND_VGRAD: state_in = ST_GRAD;
               KIND_BLEND: state_in = (req_alpha == 8'd0) ? ST_RESP : ST_RUN;
               KIND_READ:  state_in = ST_READ;
               default:    state_in = ST_RESP;
            endcase
         end
         ST_GRAD: if (dstep_ff == 5'd24) state_in = ST_RUN;
         ST_RUN: begin
            mem_we = pix_done;
            if (!run_live) state_in = ST_RESP;
            else if (pix_done && row_end && grad_next) state_in = ST_GRAD;
         end
         ST_READ: if (dstep_ff == 5'd1) state_in = ST_RESP;
         ST_RESP: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   // Command datapath.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: if (req_valid) begin
            cnt_ff   <= '0;
            rcol_ff  <= '0;
            ca_ff    <= req_color_a;
            cb_ff    <= req_color_b;
            col_ff   <= req_color_a;
            a_ff     <= req_alpha;
            phase_ff <= 1'b0;
            ytop_ff  <= ry;
            span_ff  <= (req_size_h < 16'sd1) ? 16'd1 : 16'(req_size_h);
            mode_ff  <= ld_mode;
            x0_ff <= ld_x0; x1_ff <= ld_x1; y1_ff <= ld_y1;
            px_ff <= ld_x0; py_ff <= ld_y0;
            ra_ff <= AW'(ry[HW-1:0]) * AW'(efw[WW-1:0]) + AW'(rx[WW-1:0]);
            rd_in_ff <= (rx >= 0 && ry >= 0 && rx < efw && ry < efh);
            rem_ff   <= '0;
            quo_ff   <= 24'(cy0 - ry) * 24'd255;
            dstep_ff <= '0;
         end
         ST_GRAD: begin
            // Restoring division, one quotient bit per cycle.
            if (dstep_ff < 5'd24) begin
               if (div_r2 >= {9'd0, span_ff}) begin
                  rem_ff <= 24'(div_r2 - {9'd0, span_ff});
                  quo_ff <= {quo_ff[22:0], 1'b1};
               end else begin
                  rem_ff <= div_r2[23:0];
                  quo_ff <= {quo_ff[22:0], 1'b0};
               end
               dstep_ff <= dstep_ff + 5'd1;
            end else begin
               col_ff <= mix24(ca_ff, cb_ff,
                               (quo_ff > 24'd255) ? 8'd255 : quo_ff[7:0]);
            end
         end
         ST_RUN: if (run_live) begin
            if (!pix_done) begin
               phase_ff <= 1'b1;
            end else begin
               phase_ff <= 1'b0;
               cnt_ff <= cnt_ff + CW'(1);
               if (!row_end) begin
                  px_ff <= px_ff + 18'sd1;
               end else begin
                  px_ff <= x0_ff;
                  py_ff <= py_ff + 18'sd1;
                  if (grad_next) begin
                     rem_ff <= '0;
                     quo_ff <= 24'(py_ff + 18'sd1 - ytop_ff) * 24'd255;
                     dstep_ff <= '0;
                  end
               end
            end
         end
         ST_READ: begin
            dstep_ff <= dstep_ff + 5'd1;
            if (dstep_ff == 5'd1) rcol_ff <= rd_in_ff ? rd_data_ff : 24'd0;
         end
         ST_RESP: ;
         default: ;
      endcase
   end

endmodule
